FILE: rtl/audio_gain_mute_average_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio gain / mute / average block
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_GAIN_MUTE_AVERAGE_MACROS_SVH
`define AUDIO_GAIN_MUTE_AVERAGE_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define AGMA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// signal pair that must never be high together while the qualifier is high
`define AGMA_ASSERT_EXCL(label, qual, a, b, msg) \
   `AGMA_ASSERT(label, (qual) |-> !((a) && (b)), msg)

`endif

FILE: rtl/agma_pkg.sv
// ----------------------------------------------------------------------------
// agma_pkg
// Widths, button codes, mode encoding and the gain bundle shared by the
// gain/mute/average datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package agma_pkg;

   localparam int SAMPLE_W = 24;
   localparam int BTN_W    = 4;
   localparam int OUT_W    = 32;
   localparam int EXP_W    = 6;
   localparam int EXP_MIN  = -24;
   localparam int EXP_MAX  = 8;
   localparam int TAPS_DEF = 32;

   // button patterns that act as commands
   localparam logic [BTN_W-1:0] BTN_NONE   = 4'h0;
   localparam logic [BTN_W-1:0] BTN_DOWN   = 4'h1;
   localparam logic [BTN_W-1:0] BTN_UP     = 4'h2;
   localparam logic [BTN_W-1:0] BTN_MUTE   = 4'h4;
   localparam logic [BTN_W-1:0] BTN_FILTER = 4'h8;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_MUTED  = 2'd1,
      MODE_FILTER = 2'd2
   } agma_mode_type;

   // gain and mode seen by the current request, after its button command
   typedef struct packed {
      logic signed [EXP_W-1:0] exponent;
      logic                    is_zero;
      logic                    filter;
      logic                    muted;
   } agma_gain_type;

endpackage

`default_nettype wire

FILE: rtl/agma_ctrl.sv
// ----------------------------------------------------------------------------
// agma_ctrl
// Button edge decoder: mode, gain exponent, zero flag and the mute save slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module agma_ctrl
   import agma_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire logic [BTN_W-1:0] buttons,
   output agma_gain_type         gain
);

   logic [BTN_W-1:0]        prev_ff,  prev_in;
   agma_mode_type           mode_ff,  mode_in;
   logic signed [EXP_W-1:0] exp_ff,   exp_in;
   logic                    zero_ff,  zero_in;
   logic signed [EXP_W-1:0] saved_exp_ff, saved_exp_in;
   logic                    saved_zero_ff, saved_zero_in;
   logic signed [EXP_W:0]   exp_wide;

   function automatic logic signed [EXP_W-1:0] clamp_exp(input logic signed [EXP_W:0] e);
      logic signed [EXP_W-1:0] r;
      if (e < EXP_MIN) begin
         r = EXP_W'(EXP_MIN);
      end else if (e > EXP_MAX) begin
         r = EXP_W'(EXP_MAX);
      end else begin
         r = e[EXP_W-1:0];
      end
      return r;
   endfunction

   assign exp_wide = (EXP_W+1)'(exp_ff);

   always_comb begin
      prev_in       = prev_ff;
      mode_in       = mode_ff;
      exp_in        = exp_ff;
      zero_in       = zero_ff;
      saved_exp_in  = saved_exp_ff;
      saved_zero_in = saved_zero_ff;
      if (buttons != prev_ff) begin
         prev_in = buttons;
         case (buttons)
            BTN_DOWN: begin
               if (mode_ff != MODE_MUTED) begin
                  exp_in  = clamp_exp(exp_wide - (EXP_W+1)'(1));
                  mode_in = MODE_NORMAL;
               end
            end
            BTN_UP: begin
               if (mode_ff != MODE_MUTED) begin
                  exp_in  = clamp_exp(exp_wide + (EXP_W+1)'(1));
                  mode_in = MODE_NORMAL;
               end
            end
            BTN_MUTE: begin
               if (mode_ff == MODE_MUTED) begin
                  exp_in  = saved_exp_ff;
                  zero_in = saved_zero_ff;
                  mode_in = MODE_NORMAL;
               end else begin
                  saved_exp_in  = exp_ff;
                  saved_zero_in = zero_ff;
                  zero_in       = 1'b1;
                  mode_in       = MODE_MUTED;
               end
            end
            BTN_FILTER: begin
               mode_in = MODE_FILTER;
            end
            BTN_NONE: begin
               if (mode_ff != MODE_MUTED) begin
                  mode_in = MODE_NORMAL;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign gain.exponent = exp_in;
   assign gain.is_zero  = zero_in;
   assign gain.filter   = (mode_in == MODE_FILTER);
   assign gain.muted    = (mode_in == MODE_MUTED);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         mode_ff       <= MODE_NORMAL;
         exp_ff        <= '0;
         zero_ff       <= 1'b0;
         saved_exp_ff  <= '0;
         saved_zero_ff <= 1'b0;
      end else if (enable) begin
         prev_ff       <= prev_in;
         mode_ff       <= mode_in;
         exp_ff        <= exp_in;
         zero_ff       <= zero_in;
         saved_exp_ff  <= saved_exp_in;
         saved_zero_ff <= saved_zero_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/agma_avg.sv
// ----------------------------------------------------------------------------
// agma_avg
// Moving average: ring of taps with a running sum, floored by the
// power-of-two shift floor(log2(TAPS)).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module agma_avg
   import agma_pkg::*;
#(
   parameter int TAPS  = TAPS_DEF,
   parameter int AVG_W = SAMPLE_W + $clog2(TAPS) - ($clog2(TAPS + 1) - 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       enable,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   output logic signed [AVG_W-1:0]         average
);

   localparam int POS_W = $clog2(TAPS);
   localparam int SHIFT = $clog2(TAPS + 1) - 1;
   localparam int SUM_W = SAMPLE_W + $clog2(TAPS);

   logic signed [SAMPLE_W-1:0] tap_mem [TAPS];
   logic [TAPS-1:0]            valid_ff;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic                       rd_valid_ff;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] oldest;
   logic signed [SUM_W-1:0]    avg_full;

   // advance the write position only on a filtered request
   always_comb begin
      pos_in = pos_ff;
      if (enable) begin
         pos_in = (pos_ff == POS_W'(TAPS - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   // the read port always fetches the entry that the next write will replace
   always_ff @(posedge clock) begin
      if (enable) begin
         tap_mem[pos_ff] <= sample;
      end
      rd_ff <= tap_mem[pos_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         pos_ff      <= '0;
         rd_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else begin
         pos_ff      <= pos_in;
         rd_valid_ff <= valid_ff[pos_in];
         if (enable) begin
            valid_ff[pos_ff] <= 1'b1;
            sum_ff           <= sum_in;
         end
      end
   end

   assign oldest   = rd_valid_ff ? rd_ff : '0;
   assign sum_in   = sum_ff - SUM_W'(oldest) + SUM_W'(sample);
   assign avg_full = sum_in >>> SHIFT;
   assign average  = avg_full[AVG_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/agma_scale.sv
// ----------------------------------------------------------------------------
// agma_scale
// Power-of-two gain: left shift for positive exponents, shift toward zero
// for negative ones, then saturation to signed 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module agma_scale
   import agma_pkg::*;
#(
   parameter int IN_W = SAMPLE_W
) (
   input  wire logic signed [IN_W-1:0] sample,
   input  wire agma_gain_type          gain,
   output logic signed [OUT_W-1:0]     result
);

   localparam int WIDE_W = IN_W + EXP_MAX + 1;

   logic signed [IN_W:0]     ext;
   logic [IN_W:0]            mag;
   logic [IN_W:0]            shr;
   logic signed [IN_W:0]     down;
   logic signed [EXP_W-1:0]  neg_exp;
   logic [4:0]               rshift;
   logic [3:0]               lshift;
   logic signed [WIDE_W-1:0] up;
   logic signed [WIDE_W-1:0] scaled;
   logic                     fits;

   assign ext     = (IN_W+1)'(sample);
   assign neg_exp = -gain.exponent;
   assign rshift  = neg_exp[4:0];
   assign lshift  = gain.exponent[3:0];

   // shift the magnitude so that negative samples truncate toward zero
   assign mag  = ext[IN_W] ? $unsigned(-ext) : $unsigned(ext);
   assign shr  = mag >> rshift;
   assign down = ext[IN_W] ? -$signed(shr) : $signed(shr);

   assign up = WIDE_W'(sample) <<< lshift;

   always_comb begin
      if (gain.is_zero) begin
         scaled = '0;
      end else if (gain.exponent[EXP_W-1]) begin
         scaled = WIDE_W'(down);
      end else begin
         scaled = up;
      end
   end

   assign fits = (scaled[WIDE_W-1:OUT_W-1] == '0) || (scaled[WIDE_W-1:OUT_W-1] == '1);

   always_comb begin
      if (fits) begin
         result = scaled[OUT_W-1:0];
      end else if (scaled[WIDE_W-1]) begin
         result = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(OUT_W-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

FILE: rtl/audio_gain_mute_average.sv
// ----------------------------------------------------------------------------
// audio_gain_mute_average
// Stereo frame gain, mute and right-channel moving average controlled by
// button pattern changes.
//
//   channel  direction  payload
//   req_     in         tdata: left_in, right_in, buttons
//   rsp_     out        tdata: left_out, right_out; tuser: filter_active, muted
//
// One request per clock cycle while the response is not stalled; the input
// register loads at the accept edge and the result register when that request
// advances, once the result register is empty or its response is taken.
// Reset is synchronous; tap valid bits clear at once, no clearing pass.
// A stalled response holds in the result register while one further
// request waits in the input register; req_tready drops only then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module audio_gain_mute_average
   import agma_pkg::*;
#(
   parameter int TAPS = TAPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // left_in[23:0], right_in[47:24], buttons[51:48]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // left_out[31:0], right_out[63:32]
   output logic [1:0]       rsp_tuser    // filter_active[0], muted[1]
);

   localparam int AVG_W = SAMPLE_W + $clog2(TAPS) - ($clog2(TAPS + 1) - 1);

   logic                       a_valid_ff;
   logic signed [SAMPLE_W-1:0] a_left_ff;
   logic signed [SAMPLE_W-1:0] a_right_ff;
   logic [BTN_W-1:0]           a_btn_ff;
   logic                       advance;

   logic                       out_valid_ff;
   logic signed [OUT_W-1:0]    out_left_ff,  out_left_in;
   logic signed [OUT_W-1:0]    out_right_ff, out_right_in;
   logic                       out_filter_ff;
   logic                       out_muted_ff;

   agma_gain_type              gain;
   logic signed [AVG_W-1:0]    average;
   logic signed [AVG_W-1:0]    right_sel;

   assign advance    = a_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_tready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         a_left_ff  <= $signed(req_tdata[23:0]);
         a_right_ff <= $signed(req_tdata[47:24]);
         a_btn_ff   <= req_tdata[51:48];
      end
   end

   agma_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .buttons (a_btn_ff),
      .gain    (gain)
   );

   agma_avg #(
      .TAPS  (TAPS),
      .AVG_W (AVG_W)
   ) u_avg (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance && gain.filter),
      .sample  (a_right_ff),
      .average (average)
   );

   assign right_sel = gain.filter ? average : AVG_W'(a_right_ff);

   agma_scale #(
      .IN_W (SAMPLE_W)
   ) u_scale_left (
      .sample (a_left_ff),
      .gain   (gain),
      .result (out_left_in)
   );

   agma_scale #(
      .IN_W (AVG_W)
   ) u_scale_right (
      .sample (right_sel),
      .gain   (gain),
      .result (out_right_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // hold the response until it is taken
   always_ff @(posedge clock) begin
      if (advance) begin
         out_left_ff   <= out_left_in;
         out_right_ff  <= out_right_in;
         out_filter_ff <= gain.filter;
         out_muted_ff  <= gain.muted;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_right_ff, out_left_ff};
   assign rsp_tuser  = {out_muted_ff, out_filter_ff};

endmodule

`default_nettype wire

FILE: rtl/agma_checker.sv
// ----------------------------------------------------------------------------
// agma_checker
// Port-level checks for the gain/mute/average block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "audio_gain_mute_average_macros.svh"

module agma_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [55:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // a stalled response keeps its contents
   `AGMA_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // muted mode always carries zero gain
   `AGMA_ASSERT(a_muted_silent, rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 64'd0, "muted response is not silent")

   // filter and mute are exclusive modes
   `AGMA_ASSERT_EXCL(a_mode_excl, rsp_tvalid, rsp_tuser[0], rsp_tuser[1], "filter and mute both set")

   // with the result register empty the input side never stalls
   `AGMA_ASSERT(a_req_open, !rsp_tvalid |-> req_tready, "request stalled with empty output")

endmodule

bind audio_gain_mute_average agma_checker u_agma_checker (.*);

`default_nettype wire
